// File: rtl/core/hfau_pkg.sv
// ----------------------------------------------------------------------------
// hfau_pkg
// Types, operation codes and helpers shared by the hex floating-point unit.
// ----------------------------------------------------------------------------
package hfau_pkg;

    // Working widths: 14 hex digits of fraction, signed excess-64 exponent.
    localparam int FRAC_W = 56;
    localparam int EXP_W  = 10;

    typedef logic signed [EXP_W-1:0] t_exp;

    // Operation codes carried in the func field.
    localparam logic [3:0] FN_LOAD  = 4'd0;
    localparam logic [3:0] FN_CMP   = 4'd1;
    localparam logic [3:0] FN_ADD   = 4'd2;
    localparam logic [3:0] FN_SUB   = 4'd3;
    localparam logic [3:0] FN_MUL   = 4'd4;
    localparam logic [3:0] FN_DIV   = 4'd5;
    localparam logic [3:0] FN_FIX16 = 4'd6;
    localparam logic [3:0] FN_FIX32 = 4'd7;
    localparam logic [3:0] FN_FLT16 = 4'd8;
    localparam logic [3:0] FN_FLT32 = 4'd9;

    // Exponent constants.
    localparam t_exp EXP_BIAS  = t_exp'(64);
    localparam t_exp EXP_MAX   = t_exp'(127);
    localparam t_exp FIX_MIN   = t_exp'(65);
    localparam t_exp FIX16_TOP = t_exp'(68);
    localparam t_exp FIX32_TOP = t_exp'(72);
    localparam t_exp FIX16_SH  = t_exp'(70);
    localparam t_exp FLT16_EXP = t_exp'(68);
    localparam t_exp FLT32_EXP = t_exp'(72);

    // Condition flags.
    typedef struct packed {
        logic c;
        logic v;
        logic g;
        logic l;
    } t_cc;

    // Packed float result together with its flags.
    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
        t_cc         cc;
    } t_fres;

    // Exponent overflow saturates exponent and fraction to all ones with the sign kept, underflow gives a clean zero.
    function automatic t_fres f_exc(input logic sign, input logic under);
        t_fres res;
        res.cc = '0;
        res.cc.v = 1'b1;
        if (under) begin
            res.hi = '0;
            res.lo = '0;
        end else begin
            res.hi = sign ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
            res.lo = 32'hFFFF_FFFF;
            res.cc.l = sign;
            res.cc.g = ~sign;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/hex_float_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// hex_float_arithmetic_unit
// Base-16 excess-64 floating-point unit with a small sequencer around one
// shared shift, add and compare datapath.
// ----------------------------------------------------------------------------
// Usage:
// One operation travels as one beat on the slave stream: operands in tdata,
// func and precision in tuser. The result leaves as one beat on the master
// stream: result words and integer in tdata, write strobes and condition
// flags in tuser. o_s_tready is high only while the sequencer is idle.
// After the input beat, both operands are normalised together one digit
// per cycle, up to 13 leading zero digits. Then: compare, divide by zero,
// unused codes and exponent range faults go straight to hand-on; load, or
// arithmetic with a zero operand, packs the result first; add aligns d (0
// to 13) digits; a subtract of unlike signs also renormalises k (0 to 13)
// digits; multiply takes one multiplier bit per cycle over 56 or 24 bits,
// then at most one renormalise shift; divide subtracts, per quotient digit
// (6 or 14), once per unit of its value and then shifts; fix makes s (0 to
// 7) digit shifts; float makes k (0 to 7) normalise shifts. The next beat
// is accepted in the cycle after the result is handed on, while it waits
// in the output register; a further result waits in the sequencer until
// the receiver takes the first.
// Reset empties the output register, idles the sequencer and sets
// hardware_fp_mode. The configuration register is written whenever i_cfg_we
// is high.
// ----------------------------------------------------------------------------
module hex_float_arithmetic_unit
    import hfau_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write: hardware_fp_mode.
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    // Slave stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: first_high, first_low, second_high, second_low, integer_operand
    input  logic [159:0] i_s_tdata,
    // tuser: func[3:0], double_precision[4]
    input  logic [4:0]   i_s_tuser,
    // Master stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: result_high, result_low, integer_result
    output logic [95:0]  o_m_tdata,
    // tuser: float_written, integer_written, flag_carry, flag_overflow,
    //        flag_greater, flag_less
    output logic [5:0]   o_m_tuser
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_ALIGN = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_FIX   = 4'd5;
    localparam logic [3:0] S_POSTN = 4'd6;
    localparam logic [3:0] S_STORE = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]        r_state, n_state;
    logic              r_hw;
    logic [3:0]        r_func, n_func;
    logic              r_dp, n_dp;
    logic [31:0]       r_iv, n_iv;
    logic              r_sa, n_sa, r_sb, n_sb, r_sr, n_sr;
    t_exp              r_ea, n_ea, r_eb, n_eb, r_er, n_er;
    logic [59:0]       r_fa, n_fa;
    logic [FRAC_W-1:0] r_fb, n_fb;
    logic [56:0]       r_fr, n_fr;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_rnd, n_rnd;
    logic              r_keep_cc, n_keep_cc;
    logic [31:0]       r_rh, n_rh, r_rl, n_rl, r_ir, n_ir;
    logic              r_fw, n_fw, r_iw, n_iw;
    t_cc               r_cc, n_cc;
    logic              r_m_valid, n_m_valid;
    logic [31:0]       r_o_rh, n_o_rh, r_o_rl, n_o_rl, r_o_ir, n_o_ir;
    logic              r_o_fw, n_o_fw, r_o_iw, n_o_iw;
    t_cc               r_o_cc, n_o_cc;

    logic              w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid & o_s_tready;

    // Sequencer and shared datapath.
    always_comb begin
        logic [31:0]       v_ah, v_al, v_bh, v_bl;
        logic              v_idp;
        logic [FRAC_W-1:0] v_af, v_bf, v_bm, v_diff;
        logic              v_abusy, v_bbusy, v_sb, v_swap, v_ge, v_neg, v_rnd_up;
        t_exp              v_d, v_lim, v_e, v_top, v_sh;
        logic [56:0]       v_sum, v_acc;
        logic [59:0]       v_fa4;
        logic [31:0]       v_t, v_mag, v_w;
        logic [23:0]       v_h;
        logic [24:0]       v_h25;
        t_fres             v_x;

        n_state   = r_state;
        n_func    = r_func;
        n_dp      = r_dp;
        n_iv      = r_iv;
        n_sa      = r_sa;
        n_sb      = r_sb;
        n_sr      = r_sr;
        n_ea      = r_ea;
        n_eb      = r_eb;
        n_er      = r_er;
        n_fa      = r_fa;
        n_fb      = r_fb;
        n_fr      = r_fr;
        n_cnt     = r_cnt;
        n_rnd     = r_rnd;
        n_keep_cc = r_keep_cc;
        n_rh      = r_rh;
        n_rl      = r_rl;
        n_ir      = r_ir;
        n_fw      = r_fw;
        n_iw      = r_iw;
        n_cc      = r_cc;
        n_o_rh    = r_o_rh;
        n_o_rl    = r_o_rl;
        n_o_ir    = r_o_ir;
        n_o_fw    = r_o_fw;
        n_o_iw    = r_o_iw;
        n_o_cc    = r_o_cc;
        n_m_valid = r_m_valid & ~i_m_tready;

        v_ah     = i_s_tdata[31:0];
        v_al     = i_s_tdata[63:32];
        v_bh     = i_s_tdata[95:64];
        v_bl     = i_s_tdata[127:96];
        v_idp    = i_s_tuser[4];
        v_af     = {v_ah[23:0], v_idp ? v_al : 32'd0};
        v_bf     = {v_bh[23:0], v_idp ? v_bl : 32'd0};
        v_abusy  = (r_fa[55:0] != '0) && (r_fa[55:52] == 4'd0);
        v_bbusy  = (r_fb != '0) && (r_fb[55:52] == 4'd0);
        v_sb     = r_sb ^ (r_func == FN_SUB);
        v_swap   = (r_ea < r_eb) || ((r_ea == r_eb) && (r_fa[55:0] < r_fb));
        v_ge     = (r_fa[55:0] >= r_fb);
        v_neg    = 1'b0;
        v_bm     = (r_dp || r_hw) ? r_fb : {r_fb[55:32], 32'd0};
        v_diff   = r_fa[55:0] - v_bm;
        v_sum    = {1'b0, r_fa[55:0]} + {1'b0, v_bm};
        v_acc    = {1'b0, r_fr[55:0]} + (r_fb[0] ? {1'b0, r_fa[55:0]} : 57'd0);
        v_fa4    = {r_fa[55:0], 4'd0};
        v_d      = '0;
        v_lim    = (r_dp || r_hw) ? t_exp'(14) : t_exp'(6);
        v_e      = '0;
        v_top    = (r_func == FN_FIX16) ? FIX16_TOP : FIX32_TOP;
        v_sh     = '0;
        v_t      = (r_func == FN_FLT16) ? {16'd0, r_iv[15:0]} : r_iv;
        v_mag    = '0;
        v_w      = '0;
        v_h      = r_fr[55:32];
        v_h25    = {1'b0, r_fr[55:32]} + 25'd1;
        v_rnd_up = r_rnd & r_fr[31];
        v_x      = f_exc(1'b0, 1'b1);

        case (r_state)
            // Take a beat and unpack both operands.
            S_IDLE: begin
                if (w_accept) begin
                    n_func    = i_s_tuser[3:0];
                    n_dp      = v_idp;
                    n_iv      = i_s_tdata[159:128];
                    n_fa      = {4'd0, v_af};
                    n_fb      = v_bf;
                    n_sa      = (v_af != '0) & v_ah[31];
                    n_sb      = (v_bf != '0) & v_bh[31];
                    n_ea      = (v_af != '0) ? t_exp'({3'd0, v_ah[30:24]}) : '0;
                    n_eb      = (v_bf != '0) ? t_exp'({3'd0, v_bh[30:24]}) : '0;
                    n_rh      = '0;
                    n_rl      = '0;
                    n_ir      = '0;
                    n_fw      = 1'b0;
                    n_iw      = 1'b0;
                    n_cc      = '0;
                    n_rnd     = 1'b0;
                    n_keep_cc = 1'b0;
                    n_state   = S_NORM;
                end
            end

            // Normalise both operands a digit per cycle, then set up the op.
            S_NORM: begin
                if (v_abusy) begin
                    n_fa = {4'd0, r_fa[51:0], 4'd0};
                    n_ea = r_ea - t_exp'(1);
                end
                if (v_bbusy) begin
                    n_fb = {r_fb[51:0], 4'd0};
                    n_eb = r_eb - t_exp'(1);
                end
                if (!v_abusy && !v_bbusy) begin
                    n_state = S_DONE;
                    case (r_func)
                        FN_LOAD: begin
                            n_fw    = 1'b1;
                            n_fr    = {1'b0, r_fb};
                            n_sr    = r_sb;
                            n_er    = r_eb;
                            n_state = S_STORE;
                        end
                        FN_CMP: begin
                            if (r_sa != r_sb) begin
                                n_cc.g = r_sb;
                                n_cc.c = ~r_sb;
                                n_cc.l = ~r_sb;
                            end else if (r_fa[55:0] == r_fb && r_ea == r_eb) begin
                                n_cc = '0;
                            end else begin
                                if (r_ea != r_eb) begin
                                    v_neg = (r_ea > r_eb) ^ r_sa;
                                end else begin
                                    v_neg = (r_fa[55:0] > r_fb) ^ r_sa;
                                end
                                n_cc.g = v_neg;
                                n_cc.c = ~v_neg;
                                n_cc.l = ~v_neg;
                            end
                        end
                        FN_ADD, FN_SUB: begin
                            n_fw  = 1'b1;
                            n_rnd = ~r_dp & r_hw;
                            if (r_fa[55:32] == 24'd0) begin
                                n_fr    = {1'b0, r_fb};
                                n_sr    = v_sb;
                                n_er    = r_eb;
                                n_state = S_STORE;
                            end else if (r_fb[55:32] == 24'd0) begin
                                n_fr    = {1'b0, r_fa[55:0]};
                                n_sr    = r_sa;
                                n_er    = r_ea;
                                n_state = S_STORE;
                            end else begin
                                if (v_swap) begin
                                    n_fa = {4'd0, r_fb};
                                    n_fb = r_fa[55:0];
                                    n_sa = v_sb;
                                    n_sb = r_sa;
                                    n_ea = r_eb;
                                    n_eb = r_ea;
                                    v_d  = r_eb - r_ea;
                                end else begin
                                    n_sb = v_sb;
                                    v_d  = r_ea - r_eb;
                                end
                                if (v_d >= v_lim) begin
                                    n_fb  = '0;
                                    n_cnt = '0;
                                end else begin
                                    n_cnt = v_d[5:0];
                                end
                                n_state = S_ALIGN;
                            end
                        end
                        FN_MUL: begin
                            n_fw  = 1'b1;
                            n_rnd = ~r_dp;
                            if (r_fa[55:32] == 24'd0 || r_fb[55:32] == 24'd0) begin
                                n_fr    = '0;
                                n_sr    = 1'b0;
                                n_er    = '0;
                                n_state = S_STORE;
                            end else begin
                                v_e  = r_ea + r_eb - EXP_BIAS;
                                n_sr = r_sa ^ r_sb;
                                if (v_e < t_exp'(0) || v_e > EXP_MAX) begin
                                    v_x  = f_exc(r_sa ^ r_sb, v_e < t_exp'(0));
                                    n_rh = v_x.hi;
                                    n_rl = v_x.lo;
                                    n_cc = v_x.cc;
                                end else begin
                                    n_er = v_e;
                                    n_fr = '0;
                                    if (r_fb[31:0] != 32'd0) begin
                                        n_cnt = 6'd56;
                                    end else begin
                                        n_fb  = {32'd0, r_fb[55:32]};
                                        n_cnt = 6'd24;
                                    end
                                    n_state = S_MUL;
                                end
                            end
                        end
                        FN_DIV: begin
                            n_rnd = ~r_dp;
                            if (r_fb[55:32] == 24'd0) begin
                                n_cc.c = 1'b1;
                                n_cc.v = 1'b1;
                            end else if (r_fa[55:32] == 24'd0) begin
                                n_fw    = 1'b1;
                                n_fr    = '0;
                                n_sr    = 1'b0;
                                n_er    = '0;
                                n_state = S_STORE;
                            end else begin
                                n_fw = 1'b1;
                                v_e  = r_ea - r_eb + EXP_BIAS;
                                n_sr = r_sa ^ r_sb;
                                if (v_e < t_exp'(0)) begin
                                    v_x  = f_exc(r_sa ^ r_sb, 1'b1);
                                    n_rh = v_x.hi;
                                    n_rl = v_x.lo;
                                    n_cc = v_x.cc;
                                end else if ((v_ge ? v_e + t_exp'(1) : v_e) > EXP_MAX) begin
                                    v_x  = f_exc(r_sa ^ r_sb, 1'b0);
                                    n_rh = v_x.hi;
                                    n_rl = v_x.lo;
                                    n_cc = v_x.cc;
                                end else begin
                                    n_er    = v_ge ? v_e + t_exp'(1) : v_e;
                                    n_fa    = v_ge ? r_fa : v_fa4;
                                    n_fr    = '0;
                                    n_cnt   = r_dp ? 6'd14 : 6'd6;
                                    n_state = S_DIV;
                                end
                            end
                        end
                        FN_FIX16, FN_FIX32: begin
                            n_iw = 1'b1;
                            if (r_fb[55:32] == 24'd0 || r_eb < FIX_MIN) begin
                                n_ir = '0;
                            end else begin
                                if (r_eb > v_top
                                        || (r_eb == v_top && r_fb[55:32] >= 24'h800000)) begin
                                    v_w    = (r_func == FN_FIX16) ? 32'h0000_7FFF
                                                                  : 32'h7FFF_FFFF;
                                    n_cc.v = 1'b1;
                                    n_cnt  = '0;
                                end else if (r_func == FN_FIX16) begin
                                    v_w   = {8'd0, r_fb[55:32]};
                                    v_sh  = FIX16_SH - r_eb;
                                    n_cnt = v_sh[5:0];
                                end else begin
                                    v_w   = {r_fb[55:32], r_fb[31:24]};
                                    v_sh  = FIX32_TOP - r_eb;
                                    n_cnt = v_sh[5:0];
                                end
                                n_fa    = {28'd0, v_w};
                                n_sr    = r_sb;
                                n_state = S_FIX;
                            end
                        end
                        FN_FLT16, FN_FLT32: begin
                            n_fw      = 1'b1;
                            n_keep_cc = 1'b1;
                            v_neg     = (r_func == FN_FLT16) ? v_t[15] : v_t[31];
                            v_mag     = v_neg ? (~v_t + 32'd1) : v_t;
                            if (r_func == FN_FLT16) begin
                                v_mag = {16'd0, v_mag[15:0]};
                                n_fr  = {1'b0, v_mag[15:0], 40'd0};
                                n_er  = FLT16_EXP;
                            end else begin
                                n_fr  = {1'b0, v_mag, 24'd0};
                                n_er  = FLT32_EXP;
                            end
                            n_sr = v_neg;
                            if (v_t != 32'd0) begin
                                n_cc.l = v_neg;
                                n_cc.g = ~v_neg;
                            end
                            n_state = S_POSTN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Shift the smaller operand right a digit per cycle, then add or subtract.
            S_ALIGN: begin
                if (r_cnt != '0) begin
                    n_fb  = {4'd0, r_fb[55:4]};
                    n_cnt = r_cnt - 6'd1;
                end else if (r_sa != r_sb) begin
                    n_fr    = {1'b0, v_diff};
                    n_sr    = r_sa;
                    n_er    = r_ea;
                    n_state = S_POSTN;
                end else begin
                    n_sr = r_sa;
                    if (v_sum[56]) begin
                        n_fr = {4'd0, v_sum[56:4]};
                        n_er = r_ea + t_exp'(1);
                    end else begin
                        n_fr = v_sum;
                        n_er = r_ea;
                    end
                    n_state = S_STORE;
                end
            end

            // Shift-and-add multiply, one multiplier bit per cycle.
            S_MUL: begin
                if (r_cnt != '0) begin
                    n_fr  = {1'b0, v_acc[56:1]};
                    n_fb  = {1'b0, r_fb[55:1]};
                    n_cnt = r_cnt - 6'd1;
                end else begin
                    n_state = S_POSTN;
                end
            end

            // Restoring divide: one compare and subtract per cycle.
            S_DIV: begin
                if (r_fa >= {4'd0, r_fb}) begin
                    n_fa = r_fa - {4'd0, r_fb};
                    n_fr = r_fr + 57'd1;
                end else begin
                    n_fa = v_fa4;
                    if (r_cnt == 6'd1) begin
                        if (!r_dp) begin
                            v_ge = (v_fa4[59:32] >= {1'b0, r_fb[55:32], 3'd0});
                            n_fr = {1'b0, r_fr[23:0], v_ge, 31'd0};
                        end
                        n_state = S_STORE;
                    end else begin
                        n_fr  = {r_fr[52:0], 4'd0};
                        n_cnt = r_cnt - 6'd1;
                    end
                end
            end

            // Fix conversion: shift out fraction digits, then apply the sign.
            S_FIX: begin
                if (r_cnt != '0) begin
                    n_fa  = {28'd0, 4'd0, r_fa[31:4]};
                    n_cnt = r_cnt - 6'd1;
                end else begin
                    v_w    = r_sr ? (~r_fa[31:0] + 32'd1) : r_fa[31:0];
                    n_cc.l = r_sr;
                    n_cc.g = ~r_sr;
                    n_ir   = (r_func == FN_FIX16) ? {16'd0, v_w[15:0]} : v_w;
                    n_state = S_DONE;
                end
            end

            // Normalise the result a digit per cycle.
            S_POSTN: begin
                if (r_fr[55:0] == '0) begin
                    n_sr    = 1'b0;
                    n_er    = '0;
                    n_state = S_STORE;
                end else if (r_fr[55:52] == 4'd0) begin
                    n_fr = {1'b0, r_fr[51:0], 4'd0};
                    n_er = r_er - t_exp'(1);
                end else begin
                    n_state = S_STORE;
                end
            end

            // Round on the guard bit, range check and pack. A product whose
            // exponent went negative while normalising underflows before
            // any rounding.
            S_STORE: begin
                v_e = r_er;
                if (v_rnd_up) begin
                    if (v_h25[24]) begin
                        v_h = {3'd0, v_h25[24:4]};
                        v_e = r_er + t_exp'(1);
                    end else begin
                        v_h = v_h25[23:0];
                    end
                end
                if (v_h == 24'd0) begin
                    n_rh = '0;
                    n_rl = '0;
                    if (!r_keep_cc) begin
                        n_cc = '0;
                    end
                end else if (v_e < t_exp'(0) || v_e > EXP_MAX
                             || (r_func == FN_MUL && r_er < t_exp'(0))) begin
                    v_x  = f_exc(r_sr, v_e < t_exp'(0) || r_er < t_exp'(0));
                    n_rh = v_x.hi;
                    n_rl = v_x.lo;
                    if (!r_keep_cc) begin
                        n_cc = v_x.cc;
                    end
                end else begin
                    n_rh = {r_sr, v_e[6:0], v_h};
                    n_rl = r_fr[31:0];
                    if (!r_keep_cc) begin
                        n_cc   = '0;
                        n_cc.l = r_sr;
                        n_cc.g = ~r_sr;
                    end
                end
                n_state = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_o_rh    = r_fw ? r_rh : 32'd0;
                    n_o_rl    = (r_fw && r_dp) ? r_rl : 32'd0;
                    n_o_ir    = r_iw ? r_ir : 32'd0;
                    n_o_fw    = r_fw;
                    n_o_iw    = r_iw;
                    n_o_cc    = r_cc;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_hw      <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_hw <= i_cfg_wdata;
            end
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_dp      <= n_dp;
        r_iv      <= n_iv;
        r_sa      <= n_sa;
        r_sb      <= n_sb;
        r_sr      <= n_sr;
        r_ea      <= n_ea;
        r_eb      <= n_eb;
        r_er      <= n_er;
        r_fa      <= n_fa;
        r_fb      <= n_fb;
        r_fr      <= n_fr;
        r_cnt     <= n_cnt;
        r_rnd     <= n_rnd;
        r_keep_cc <= n_keep_cc;
        r_rh      <= n_rh;
        r_rl      <= n_rl;
        r_ir      <= n_ir;
        r_fw      <= n_fw;
        r_iw      <= n_iw;
        r_cc      <= n_cc;
        r_o_rh    <= n_o_rh;
        r_o_rl    <= n_o_rl;
        r_o_ir    <= n_o_ir;
        r_o_fw    <= n_o_fw;
        r_o_iw    <= n_o_iw;
        r_o_cc    <= n_o_cc;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_o_ir, r_o_rl, r_o_rh};
    assign o_m_tuser  = {r_o_cc.l, r_o_cc.g, r_o_cc.v, r_o_cc.c, r_o_iw, r_o_fw};

`ifndef ASSERT_OFF
    // An accepted beat keeps the sequencer busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("sequencer ready straight after an accepted beat");

    // A result never writes both a float and an integer.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("float and integer written together");

    // Without a float write both result words are zero.
    a_float_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[63:0] == 64'd0))
        else $error("float words not cleared");

    // Without an integer write the integer result is zero.
    a_int_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[1]) |-> (o_m_tdata[95:64] == 32'd0))
        else $error("integer result not cleared");

    // Underflow of a float result gives a clean zero.
    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0] && o_m_tuser[3] && !o_m_tuser[4] && !o_m_tuser[5])
            |-> (o_m_tdata[31:0] == 32'd0))
        else $error("underflow result not zero");
`endif

endmodule
